>>> hw/rtl/dxlt_pkg.sv
// Shared types and constants for the desktop exec line tokenizer.
`default_nettype none

package dxlt_pkg;

  // Tokenizer modes
  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_FIELD = 3'd1;
  localparam logic [2:0] MODE_ESC   = 3'd2;
  localparam logic [2:0] MODE_QUOTE = 3'd3;
  localparam logic [2:0] MODE_QESC  = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_CHAR      = 3'd0;
  localparam logic [2:0] KIND_COMMIT    = 3'd1;
  localparam logic [2:0] KIND_FIRST_URI = 3'd2;
  localparam logic [2:0] KIND_ALL_URIS  = 3'd3;
  localparam logic [2:0] KIND_ICON      = 3'd4;
  localparam logic [2:0] KIND_NAME      = 3'd5;

  // Input action codes
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOL  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_HAS_ICON     = 2'd0;
  localparam logic [1:0] REG_FORCE_APPEND = 2'd1;
  localparam logic [1:0] REG_URI_COUNT    = 2'd2;

  // Byte constants
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_LC_U    = 8'h75;
  localparam logic [7:0] CH_UC_F    = 8'h46;
  localparam logic [7:0] CH_UC_U    = 8'h55;
  localparam logic [7:0] CH_LC_I    = 8'h69;
  localparam logic [7:0] CH_LC_C    = 8'h63;

  // Result queue depth and pointer width
  localparam int QDEPTH = 4;
  localparam int QPTRW  = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code_out;
    logic       last_of_run;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/desktop_exec_line_tokenizer_top.sv
// Top level of the desktop exec line tokenizer.
// A result is written into the result queue on its input transfer.
// Throughput: one input item per cycle while s_axis_tready is high; an
// end-of-line item that yields a commit and an all-URIs insert gives two
// results, absorbed by a four-entry result queue (input ready while at most two results queued).
// Reset (synchronous, rst high) clears registers, tokenizer state and queue.
`default_nettype none

module desktop_exec_line_tokenizer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  wire logic [0:0] s_axis_tuser,   // [0] action
  // result stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] char_code_out
  output logic [2:0]      m_axis_tuser,   // [2:0] kind
  output logic            m_axis_tlast,   // last_of_run
  // configuration writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  // Configuration registers
  logic       has_icon;
  logic       force_append;
  logic [7:0] uri_count;

  // Tokenizer state
  logic [2:0] mode, mode_next;
  logic [7:0] quote_byte, quote_byte_next;
  logic       word_nonempty, word_nonempty_next;
  logic       uri_code_seen, uri_code_seen_next;

  // Result queue
  dxlt_pkg::res_t                  queue [dxlt_pkg::QDEPTH];
  logic [dxlt_pkg::QPTRW-1:0]      wr_ptr, rd_ptr;
  logic [dxlt_pkg::QPTRW:0]        count, count_next;

  logic           in_xfer, out_xfer;
  logic [1:0]     n_res;
  dxlt_pkg::res_t res0, res1;
  logic           action;
  logic [7:0]     ch;
  logic           is_space;

  assign action    = s_axis_tuser[0];
  assign ch        = s_axis_tdata;
  assign cfg_ready = 1'b1;

  // Leave room for the two results an end-of-line item may produce.
  assign s_axis_tready = (count <= (dxlt_pkg::QPTRW+1)'(dxlt_pkg::QDEPTH - 2));
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign out_xfer      = m_axis_tvalid & m_axis_tready;

  assign m_axis_tuser = queue[rd_ptr].kind;
  assign m_axis_tdata = queue[rd_ptr].char_code_out;
  assign m_axis_tlast = queue[rd_ptr].last_of_run;

  assign is_space = (ch == dxlt_pkg::CH_SPACE) ||
                    ((ch >= dxlt_pkg::CH_TAB) && (ch <= dxlt_pkg::CH_CR));

  // Classify one byte against the current mode; build up to two results.
  always_comb begin
    mode_next          = mode;
    quote_byte_next    = quote_byte;
    word_nonempty_next = word_nonempty;
    uri_code_seen_next = uri_code_seen;
    n_res              = 2'd0;
    res0               = '{kind: dxlt_pkg::KIND_CHAR, char_code_out: 8'h00, last_of_run: 1'b1};
    res1               = '{kind: dxlt_pkg::KIND_ALL_URIS, char_code_out: 8'h00, last_of_run: 1'b1};

    if (action == dxlt_pkg::ACT_EOL) begin
      // Commit the pending word, then optionally force all URIs.
      if (word_nonempty) begin
        res0.kind = dxlt_pkg::KIND_COMMIT;
        if (!uri_code_seen && force_append) begin
          res0.last_of_run = 1'b0;
          n_res = 2'd2;
        end else begin
          n_res = 2'd1;
        end
      end else if (!uri_code_seen && force_append) begin
        res0.kind = dxlt_pkg::KIND_ALL_URIS;
        n_res = 2'd1;
      end
      mode_next          = dxlt_pkg::MODE_PLAIN;
      quote_byte_next    = 8'h00;
      word_nonempty_next = 1'b0;
      uri_code_seen_next = 1'b0;
    end else begin
      case (mode)
        dxlt_pkg::MODE_FIELD: begin
          mode_next = dxlt_pkg::MODE_PLAIN;
          if (ch == dxlt_pkg::CH_PERCENT) begin
            res0.char_code_out = ch;
            word_nonempty_next = 1'b1;
            n_res = 2'd1;
          end else if (ch == dxlt_pkg::CH_LC_F || ch == dxlt_pkg::CH_LC_U) begin
            uri_code_seen_next = 1'b1;
            res0.kind = dxlt_pkg::KIND_FIRST_URI;
            n_res = (uri_count != 8'h00) ? 2'd1 : 2'd0;
          end else if (ch == dxlt_pkg::CH_UC_F || ch == dxlt_pkg::CH_UC_U) begin
            uri_code_seen_next = 1'b1;
            res0.kind = dxlt_pkg::KIND_ALL_URIS;
            n_res = 2'd1;
          end else if (ch == dxlt_pkg::CH_LC_I) begin
            res0.kind = dxlt_pkg::KIND_ICON;
            n_res = has_icon ? 2'd1 : 2'd0;
          end else if (ch == dxlt_pkg::CH_LC_C) begin
            res0.kind = dxlt_pkg::KIND_NAME;
            n_res = 2'd1;
          end
        end
        dxlt_pkg::MODE_ESC: begin
          mode_next          = dxlt_pkg::MODE_PLAIN;
          res0.char_code_out = ch;
          word_nonempty_next = 1'b1;
          n_res = 2'd1;
        end
        dxlt_pkg::MODE_QUOTE: begin
          if (ch == dxlt_pkg::CH_BSLASH) begin
            mode_next = dxlt_pkg::MODE_QESC;
          end else if (ch == quote_byte) begin
            mode_next = dxlt_pkg::MODE_PLAIN;
          end else begin
            res0.char_code_out = ch;
            word_nonempty_next = 1'b1;
            n_res = 2'd1;
          end
        end
        dxlt_pkg::MODE_QESC: begin
          mode_next          = dxlt_pkg::MODE_QUOTE;
          res0.char_code_out = ch;
          word_nonempty_next = 1'b1;
          n_res = 2'd1;
        end
        default: begin
          // Plain mode; undefined codes behave the same.
          mode_next = dxlt_pkg::MODE_PLAIN;
          if (ch == dxlt_pkg::CH_DQUOTE || ch == dxlt_pkg::CH_SQUOTE) begin
            mode_next       = dxlt_pkg::MODE_QUOTE;
            quote_byte_next = ch;
          end else if (ch == dxlt_pkg::CH_PERCENT) begin
            mode_next = dxlt_pkg::MODE_FIELD;
          end else if (ch == dxlt_pkg::CH_BSLASH) begin
            mode_next = dxlt_pkg::MODE_ESC;
          end else if (is_space) begin
            if (word_nonempty) begin
              res0.kind          = dxlt_pkg::KIND_COMMIT;
              word_nonempty_next = 1'b0;
              n_res = 2'd1;
            end
          end else begin
            res0.char_code_out = ch;
            word_nonempty_next = 1'b1;
            n_res = 2'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (in_xfer) begin
      count_next = count_next + (dxlt_pkg::QPTRW+1)'(n_res);
    end
    if (out_xfer) begin
      count_next = count_next - (dxlt_pkg::QPTRW+1)'(1);
    end
  end

  // Configuration registers: writes are always accepted and registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_icon     <= 1'b0;
      force_append <= 1'b0;
      uri_count    <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dxlt_pkg::REG_HAS_ICON:     has_icon     <= cfg_data[0];
        dxlt_pkg::REG_FORCE_APPEND: force_append <= cfg_data[0];
        dxlt_pkg::REG_URI_COUNT:    uri_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tokenizer state and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= dxlt_pkg::MODE_PLAIN;
      quote_byte    <= 8'h00;
      word_nonempty <= 1'b0;
      uri_code_seen <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (in_xfer) begin
        mode          <= mode_next;
        quote_byte    <= quote_byte_next;
        word_nonempty <= word_nonempty_next;
        uri_code_seen <= uri_code_seen_next;
        wr_ptr        <= wr_ptr + dxlt_pkg::QPTRW'(n_res);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + dxlt_pkg::QPTRW'(1);
      end
      count <= count_next;
    end
  end

  // Queue payload: write the new results behind the tail.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (n_res != 2'd0) begin
        queue[wr_ptr] <= res0;
      end
      if (n_res == 2'd2) begin
        queue[wr_ptr + dxlt_pkg::QPTRW'(1)] <= res1;
      end
    end
  end

endmodule

`default_nettype wire
